FILE: rtl/core/ipv4_longest_prefix_router_unit_macros.svh
// Assertion macros shared by the router unit.
`ifndef IPV4_LONGEST_PREFIX_ROUTER_UNIT_MACROS_SVH
`define IPV4_LONGEST_PREFIX_ROUTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define IPLPR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IPLPR_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define IPLPR_ASSERT(label, clk, rst, prop, msg)
`define IPLPR_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

FILE: rtl/core/iplpr_pkg.sv
`default_nettype none

package iplpr_pkg;

   localparam int ROUTES_DEFAULT = 16;

   localparam logic ACTION_ADD = 1'b0;

   typedef enum logic [2:0] {
      RSP_FORWARDED   = 3'd0,
      RSP_DROP_TTL    = 3'd1,
      RSP_DROP_NOROUTE = 3'd2,
      RSP_ADDED       = 3'd3,
      RSP_FULL        = 3'd4
   } rsp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic [31:0] prefix;
      logic [5:0]  len;
      logic        direct;
      logic [31:0] gateway;
      logic [1:0]  iface;
   } route_entry_type;

   typedef struct packed {
      logic           load;
      logic           write;
      logic           scan_start;
      logic           scan_step;
      logic           respond;
      rsp_status_type resp_code;
   } dp_cmd_type;

   typedef struct packed {
      logic is_add;
      logic full;
      logic ttl_low;
      logic table_empty;
      logic scan_done;
      logic found;
   } dp_status_type;

   function automatic logic [31:0] len_mask(input logic [5:0] len);
      logic [31:0] mask;
      if (len == 6'd0) begin
         mask = 32'd0;
      end else if (len >= 6'd32) begin
         mask = 32'hFFFF_FFFF;
      end else begin
         mask = ~(32'hFFFF_FFFF >> len);
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ipv4_longest_prefix_router_unit.sv
`default_nettype none
// Channel    Handshake              Payload
// request    start, busy            req_action .. req_ttl_in
// response   rsp_strobe             rsp_status, rsp_out_iface, rsp_hop_addr, rsp_ttl_out
//
// A request is taken when start is high and busy is low; every request gives one response.
// Add requests and requests dropped for ttl or an empty table answer from decode.
// A lookup walks the table one entry a cycle through the route memory read port,
// so it answers from the finish state after comparing every stored route, at most ROUTES.
// Reset empties the table at once; route memory itself is never cleared.
// The response strobe lasts one cycle and cannot be held off by the receiver.

module ipv4_longest_prefix_router_unit #(
   parameter int ROUTES = iplpr_pkg::ROUTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_action,
   input  wire logic [31:0] req_address,
   input  wire logic [5:0]  req_prefix_len,
   input  wire logic        req_has_next_hop,
   input  wire logic [31:0] req_next_hop_in,
   input  wire logic [1:0]  req_iface_in,
   input  wire logic [7:0]  req_ttl_in,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_status,
   output logic [1:0]       rsp_out_iface,
   output logic [31:0]      rsp_hop_addr,
   output logic [7:0]       rsp_ttl_out
);
   import iplpr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   iplpr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   iplpr_datapath #(
      .ROUTES (ROUTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_action       (req_action),
      .req_address      (req_address),
      .req_prefix_len   (req_prefix_len),
      .req_has_next_hop (req_has_next_hop),
      .req_next_hop_in  (req_next_hop_in),
      .req_iface_in     (req_iface_in),
      .req_ttl_in       (req_ttl_in),
      .cmd              (cmd),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_out_iface    (rsp_out_iface),
      .rsp_hop_addr     (rsp_hop_addr),
      .rsp_ttl_out      (rsp_ttl_out)
   );

endmodule

`default_nettype wire

FILE: rtl/core/iplpr_ctrl.sv
`default_nettype none
`include "ipv4_longest_prefix_router_unit_macros.svh"

module iplpr_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire iplpr_pkg::dp_status_type status,
   output iplpr_pkg::dp_cmd_type         cmd
);
   import iplpr_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_add || status.ttl_low || status.table_empty) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.resp_code = RSP_FORWARDED;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            cmd.load = start;
         end
         ST_DECODE: begin
            if (status.is_add) begin
               cmd.respond = 1'b1;
               if (status.full) begin
                  cmd.resp_code = RSP_FULL;
               end else begin
                  cmd.write = 1'b1;
                  cmd.resp_code = RSP_ADDED;
               end
            end else if (status.ttl_low) begin
               cmd.respond = 1'b1;
               cmd.resp_code = RSP_DROP_TTL;
            end else if (status.table_empty) begin
               cmd.respond = 1'b1;
               cmd.resp_code = RSP_DROP_NOROUTE;
            end else begin
               cmd.scan_start = 1'b1;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_FINISH: begin
            cmd.respond = 1'b1;
            if (status.found) begin
               cmd.resp_code = RSP_FORWARDED;
            end else begin
               cmd.resp_code = RSP_DROP_NOROUTE;
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   `IPLPR_ASSERT(a_start_decodes, clock, reset,
      (state_ff == ST_IDLE && start) |=> (state_ff == ST_DECODE),
      "accepted request did not reach decode")
   `IPLPR_ASSERT(a_respond_state, clock, reset,
      cmd.respond |-> (state_ff == ST_DECODE || state_ff == ST_FINISH),
      "response issued outside decode or finish")
   `IPLPR_ASSERT_NEVER(a_write_full, clock, reset, cmd.write && status.full,
      "route written into a full table")

endmodule

`default_nettype wire

FILE: rtl/core/iplpr_datapath.sv
`default_nettype none
`include "ipv4_longest_prefix_router_unit_macros.svh"

module iplpr_datapath #(
   parameter int ROUTES = iplpr_pkg::ROUTES_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_action,
   input  wire logic [31:0]              req_address,
   input  wire logic [5:0]               req_prefix_len,
   input  wire logic                     req_has_next_hop,
   input  wire logic [31:0]              req_next_hop_in,
   input  wire logic [1:0]               req_iface_in,
   input  wire logic [7:0]               req_ttl_in,
   input  wire iplpr_pkg::dp_cmd_type    cmd,
   output iplpr_pkg::dp_status_type      status,
   output logic                          rsp_strobe,
   output logic [2:0]                    rsp_status,
   output logic [1:0]                    rsp_out_iface,
   output logic [31:0]                   rsp_hop_addr,
   output logic [7:0]                    rsp_ttl_out
);
   import iplpr_pkg::*;

   localparam int CNT_W = $clog2(ROUTES + 1);
   localparam int IDX_W = (ROUTES > 1) ? $clog2(ROUTES) : 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ROUTES);

   route_entry_type mem [ROUTES];
   route_entry_type rdata_ff;
   route_entry_type wr_entry;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] rd_idx_ff;
   logic             cmp_valid_ff;
   logic             cmp_last_ff;

   logic        action_ff;
   logic [31:0] address_ff;
   logic [5:0]  prefix_len_ff;
   logic        has_next_hop_ff;
   logic [31:0] next_hop_ff;
   logic [1:0]  iface_ff;
   logic [7:0]  ttl_ff;

   logic        found_ff;
   logic [5:0]  best_len_ff;
   logic        best_direct_ff;
   logic [31:0] best_gateway_ff;
   logic [1:0]  best_iface_ff;

   logic        rsp_strobe_ff;
   logic [2:0]  rsp_status_ff;
   logic [1:0]  rsp_iface_ff;
   logic [31:0] rsp_hop_ff;
   logic [7:0]  rsp_ttl_ff;

   logic        issue;
   logic        match;
   logic        better;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff       <= req_action;
         address_ff      <= req_address;
         prefix_len_ff   <= req_prefix_len;
         has_next_hop_ff <= req_has_next_hop;
         next_hop_ff     <= req_next_hop_in;
         iface_ff        <= req_iface_in;
         ttl_ff          <= req_ttl_in;
      end
   end

   always_comb begin
      wr_entry.prefix  = address_ff;
      wr_entry.len     = (prefix_len_ff > 6'd32) ? 6'd32 : prefix_len_ff;
      wr_entry.direct  = ~has_next_hop_ff;
      wr_entry.gateway = has_next_hop_ff ? next_hop_ff : 32'd0;
      wr_entry.iface   = iface_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[count_ff[IDX_W-1:0]] <= wr_entry;
      end
      rdata_ff <= mem[rd_idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.write) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   assign issue = (rd_idx_ff != count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         cmp_last_ff  <= 1'b0;
      end else if (cmd.scan_start) begin
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         cmp_last_ff  <= 1'b0;
      end else if (cmd.scan_step) begin
         cmp_valid_ff <= issue;
         cmp_last_ff  <= ((rd_idx_ff + 1'b1) == count_ff);
         if (issue) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
      end
   end

   assign match  = ((address_ff ^ rdata_ff.prefix) & len_mask(rdata_ff.len)) == 32'd0;
   assign better = cmp_valid_ff && match && (!found_ff || (rdata_ff.len > best_len_ff));

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         found_ff <= 1'b0;
      end else if (cmd.scan_step && better) begin
         found_ff        <= 1'b1;
         best_len_ff     <= rdata_ff.len;
         best_direct_ff  <= rdata_ff.direct;
         best_gateway_ff <= rdata_ff.gateway;
         best_iface_ff   <= rdata_ff.iface;
      end
   end

   always_comb begin
      status.is_add      = (action_ff == ACTION_ADD);
      status.full        = (count_ff == FULL_COUNT);
      status.ttl_low     = (ttl_ff <= 8'd1);
      status.table_empty = (count_ff == '0);
      status.scan_done   = cmp_valid_ff && cmp_last_ff;
      status.found       = found_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status_ff <= cmd.resp_code;
         if (cmd.resp_code == RSP_FORWARDED) begin
            rsp_iface_ff <= best_iface_ff;
            rsp_hop_ff   <= best_direct_ff ? address_ff : best_gateway_ff;
            rsp_ttl_ff   <= ttl_ff - 8'd1;
         end else begin
            rsp_iface_ff <= 2'd0;
            rsp_hop_ff   <= 32'd0;
            rsp_ttl_ff   <= 8'd0;
         end
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_iface = rsp_iface_ff;
   assign rsp_hop_addr  = rsp_hop_ff;
   assign rsp_ttl_out   = rsp_ttl_ff;

   `IPLPR_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > FULL_COUNT, "route count above table size")
   `IPLPR_ASSERT(a_write_counts, clock, reset, cmd.write |=> (count_ff == $past(count_ff) + 1'b1), "route write did not advance the count")
   `IPLPR_ASSERT(a_fwd_ttl, clock, reset, (rsp_strobe_ff && rsp_status_ff == RSP_FORWARDED) |-> (rsp_ttl_ff != 8'd0), "forwarded request with expired ttl")

endmodule

`default_nettype wire

FILE: verif/ipv4_longest_prefix_router_unit_tb.sv
`timescale 1ns / 100ps

module ipv4_longest_prefix_router_unit_tb;
   import iplpr_pkg::*;

   localparam int TABLE_SIZE = 16;
   localparam logic ACTION_FORWARD = 1'b1;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 360;

   typedef struct {
      logic        action;
      logic [31:0] address;
      logic [5:0]  prefix_len;
      logic        has_next_hop;
      logic [31:0] gateway_addr;
      logic [1:0]  iface;
      logic [7:0]  ttl;
   } route_request_type;

   typedef struct {
      rsp_status_type status;
      logic [1:0]     iface;
      logic [31:0]    hop;
      logic [7:0]     ttl;
   } route_response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_action = 1'b0;
   logic [31:0] req_address = '0;
   logic [5:0]  req_prefix_len = '0;
   logic        req_has_next_hop = 1'b0;
   logic [31:0] req_next_hop_in = '0;
   logic [1:0]  req_iface_in = '0;
   logic [7:0]  req_ttl_in = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [1:0]  rsp_out_iface;
   logic [31:0] rsp_hop_addr;
   logic [7:0]  rsp_ttl_out;

   logic [31:0] tbl_prefix [TABLE_SIZE];
   logic [5:0]  tbl_len [TABLE_SIZE];
   logic        tbl_direct [TABLE_SIZE];
   logic [31:0] tbl_gateway [TABLE_SIZE];
   logic [1:0]  tbl_iface [TABLE_SIZE];
   int unsigned tbl_count = 0;

   route_response_type pending_responses[$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   int sender_idle_pct = 0;

   ipv4_longest_prefix_router_unit #(
      .ROUTES(TABLE_SIZE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_address(req_address),
      .req_prefix_len(req_prefix_len),
      .req_has_next_hop(req_has_next_hop),
      .req_next_hop_in(req_next_hop_in),
      .req_iface_in(req_iface_in),
      .req_ttl_in(req_ttl_in),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_out_iface(rsp_out_iface),
      .rsp_hop_addr(rsp_hop_addr),
      .rsp_ttl_out(rsp_ttl_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] route_mask(input logic [5:0] len);
      if (len >= 6'd32) begin
         return 32'hFFFF_FFFF;
      end
      return 32'hFFFF_FFFF << (32 - int'(len));
   endfunction

   function automatic route_response_type predict_route_response(input route_request_type r);
      route_response_type rsp;
      logic [5:0]         plen;
      logic [31:0]        m;
      logic               hit;
      int                 best;
      int                 i;
      rsp.status = RSP_FORWARDED;
      rsp.iface = '0;
      rsp.hop = '0;
      rsp.ttl = '0;
      if (r.action == ACTION_ADD) begin
         if (tbl_count >= TABLE_SIZE) begin
            rsp.status = RSP_FULL;
            return rsp;
         end
         plen = (r.prefix_len > 6'd32) ? 6'd32 : r.prefix_len;
         tbl_prefix[tbl_count] = r.address;
         tbl_len[tbl_count] = plen;
         tbl_direct[tbl_count] = !r.has_next_hop;
         tbl_gateway[tbl_count] = r.has_next_hop ? r.gateway_addr : 32'd0;
         tbl_iface[tbl_count] = r.iface;
         tbl_count++;
         rsp.status = RSP_ADDED;
         return rsp;
      end
      if (r.ttl <= 8'd1) begin
         rsp.status = RSP_DROP_TTL;
         return rsp;
      end
      hit = 1'b0;
      best = 0;
      for (i = 0; i < int'(tbl_count); i++) begin
         m = route_mask(tbl_len[i]);
         if (((r.address & m) == (tbl_prefix[i] & m)) && (!hit || tbl_len[i] > tbl_len[best])) begin
            hit = 1'b1;
            best = i;
         end
      end
      if (!hit) begin
         rsp.status = RSP_DROP_NOROUTE;
         return rsp;
      end
      rsp.iface = tbl_iface[best];
      rsp.hop = tbl_direct[best] ? r.address : tbl_gateway[best];
      rsp.ttl = r.ttl - 8'd1;
      return rsp;
   endfunction

   function automatic route_request_type add_item(input logic [31:0] prefix, input logic [5:0] len,
                                                  input logic has_gw, input logic [31:0] gw,
                                                  input logic [1:0] iface);
      route_request_type r;
      r.action = ACTION_ADD;
      r.address = prefix;
      r.prefix_len = len;
      r.has_next_hop = has_gw;
      r.gateway_addr = gw;
      r.iface = iface;
      r.ttl = 8'($urandom);
      return r;
   endfunction

   function automatic route_request_type forward_item(input logic [31:0] dest,
                                                      input logic [7:0] ttl);
      route_request_type r;
      r.action = ACTION_FORWARD;
      r.address = dest;
      r.prefix_len = 6'($urandom);
      r.has_next_hop = 1'($urandom);
      r.gateway_addr = $urandom;
      r.iface = 2'($urandom);
      r.ttl = ttl;
      return r;
   endfunction

   task automatic send_request(input route_request_type r);
      route_response_type want;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_action <= r.action;
      req_address <= r.address;
      req_prefix_len <= r.prefix_len;
      req_has_next_hop <= r.has_next_hop;
      req_next_hop_in <= r.gateway_addr;
      req_iface_in <= r.iface;
      req_ttl_in <= r.ttl;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      want = predict_route_response(r);
      pending_responses.insert(pending_responses.size(), want);
   endtask

   task automatic test_empty_table();
      send_request(forward_item(32'h0A01_0203, 8'd64));
      send_request(forward_item(32'hFFFF_FFFF, 8'd0));
   endtask

   task automatic test_route_adds();
      send_request(add_item(32'h0A00_0000, 6'd8, 1'b1, 32'hC0A8_0001, 2'd1));
      send_request(add_item(32'h0A01_0000, 6'd16, 1'b0, 32'hFFFF_FFFF, 2'd2));
      send_request(add_item(32'h0A01_0000, 6'd16, 1'b1, 32'hFFFF_FFFF, 2'd3));
      send_request(add_item(32'hFFFF_FFFF, 6'd32, 1'b0, 32'h0000_0000, 2'd3));
      send_request(add_item(32'hC0A8_0155, 6'd63, 1'b1, 32'h0102_0304, 2'd0));
      send_request(add_item(32'hAC10_FFFF, 6'd12, 1'b1, 32'h0A0A_0A0A, 2'd2));
   endtask

   task automatic test_longest_match();
      send_request(forward_item(32'hC000_0201, 8'd64));
      send_request(forward_item(32'h0A01_0505, 8'd255));
      send_request(forward_item(32'h0A02_0304, 8'd64));
      send_request(forward_item(32'hFFFF_FFFF, 8'd100));
      send_request(forward_item(32'hC0A8_0155, 8'd64));
      send_request(forward_item(32'hC0A8_0154, 8'd64));
      send_request(forward_item(32'hAC1F_0001, 8'd2));
      send_request(forward_item(32'h0A01_0101, 8'd1));
   endtask

   task automatic test_default_route();
      send_request(add_item(32'hDEAD_BEEF, 6'd0, 1'b1, 32'h0A00_0001, 2'd0));
      send_request(forward_item(32'h0808_0808, 8'd64));
      send_request(forward_item(32'h0000_0000, 8'd255));
   endtask

   task automatic test_table_full();
      while (tbl_count < TABLE_SIZE) begin
         send_request(add_item($urandom, 6'($urandom_range(0, 63)), 1'($urandom), $urandom,
                               2'($urandom)));
      end
      send_request(add_item(32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 2'd3));
   endtask

   task automatic test_random_traffic(input int idle_pct, input int items);
      route_request_type r;
      logic [31:0]       m;
      int                pick;
      int                idx;
      int                n;
      sender_idle_pct = idle_pct;
      for (n = 0; n < items; n++) begin
         pick = $urandom_range(99);
         idx = $urandom_range(0, tbl_count - 1);
         m = route_mask(tbl_len[idx]);
         if (pick < 4) begin
            r = add_item(tbl_prefix[idx], tbl_len[idx], 1'($urandom), $urandom, 2'($urandom));
         end else if (pick < 10) begin
            r = add_item($urandom, 6'($urandom_range(0, 63)), 1'($urandom), $urandom,
                         2'($urandom));
         end else if (pick < 15) begin
            r = forward_item((tbl_prefix[idx] & m) | ($urandom & ~m), 8'($urandom_range(0, 1)));
         end else if (pick < 30) begin
            r = forward_item($urandom, 8'($urandom));
         end else begin
            r = forward_item((tbl_prefix[idx] & m) | ($urandom & ~m),
                             8'($urandom_range(2, 255)));
         end
         send_request(r);
      end
   endtask

   always @(posedge clock) begin
      route_response_type want;
      if (!reset && rsp_strobe) begin
         if (pending_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected response: status %0d iface %0d hop %h ttl %0d",
                        rsp_status, rsp_out_iface, rsp_hop_addr, rsp_ttl_out);
            end
         end else begin
            want = pending_responses.pop_front();
            if (rsp_status !== want.status || rsp_out_iface !== want.iface ||
                rsp_hop_addr !== want.hop || rsp_ttl_out !== want.ttl) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected status %0d iface %0d hop %h ttl %0d",
                           want.status, want.iface, want.hop, want.ttl);
                  $display("          actual   status %0d iface %0d hop %h ttl %0d",
                           rsp_status, rsp_out_iface, rsp_hop_addr, rsp_ttl_out);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_route_adds();
      test_longest_match();
      test_default_route();
      test_table_full();
      test_random_traffic(0, RANDOM_ITEMS);
      test_random_traffic(81, RANDOM_ITEMS);
      test_random_traffic(24, RANDOM_ITEMS);
      start <= 1'b0;
      while (pending_responses.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: ipv4_longest_prefix_router_unit.f
+incdir+rtl/core
rtl/core/iplpr_pkg.sv
rtl/core/iplpr_ctrl.sv
rtl/core/iplpr_datapath.sv
rtl/core/ipv4_longest_prefix_router_unit.sv
verif/ipv4_longest_prefix_router_unit_tb.sv
